// ===== rtl/core/sitda_pkg.sv =====
// Shared widths, ASCII codes and state encoding for the decimal text unit.
package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Double-dabble correction of one BCD digit before the shift
  function automatic logic [3:0] add3(input logic [3:0] d);
    if (d >= 4'd5) begin
      return d + 4'd3;
    end else begin
      return d;
    end
  endfunction

endpackage

// ===== rtl/core/sitda_if.sv =====
// Valid/ready channel interfaces for the integer input and the character output.
interface sitda_in_if import sitda_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per request.
//
// Each accepted integer is rendered as its decimal text: a '-' for a negative value,
// then the digits most significant first without leading zeros, the final character
// flagged by last_char. The magnitude is converted by a bit-serial double-dabble loop,
// one input bit per cycle into a 10-digit BCD shift register; the BCD register is then
// shifted out one digit per cycle while the output slot is free (leading zeros are
// dropped without a request). The '-' goes out during conversion if the output slot
// is free, else ahead of the first digit. A new integer is taken once the previous
// one's last digit sits in the output register.
module signed_int_to_decimal_ascii_unit import sitda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sitda_in_if.sink    in_chan,
  sitda_out_if.source out_chan
);

  state_t                 state_r, state_nxt;
  logic [VALUE_W-1:0]     mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                   pend_minus_r, pend_minus_nxt;
  logic                   seen_r, seen_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   in_fire;
  logic                   slot_free;
  logic [3:0]             top_dig;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_fire            = in_chan.valid && in_chan.ready;
  assign slot_free          = !out_valid_r || out_chan.ready;
  assign top_dig            = bcd_r[BCD_W-1 -: 4];
  assign out_chan.valid     = out_valid_r;
  assign out_chan.character = out_char_r;
  assign out_chan.last_char = out_last_r;

  // Per-digit add-3 correction, digits are independent
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = add3(bcd_r[4*i +: 4]);
    end
  end

  // Sequencer, conversion loop and output register
  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    bcd_nxt        = bcd_r;
    bit_cnt_nxt    = bit_cnt_r;
    dig_cnt_nxt    = dig_cnt_r;
    pend_minus_nxt = pend_minus_r;
    seen_nxt       = seen_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pend_minus_nxt = in_chan.value[VALUE_W-1];
          mag_nxt        = in_chan.value[VALUE_W-1] ? (~in_chan.value + 1'b1)
                                                    : in_chan.value;
          bcd_nxt        = '0;
          bit_cnt_nxt    = '0;
          seen_nxt       = 1'b0;
          state_nxt      = ST_CONV;
        end
      end
      ST_CONV: begin
        // one magnitude bit per cycle into the BCD register
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          dig_cnt_nxt = DIG_CNT_W'(BCD_DIGITS);
          state_nxt   = ST_EMIT;
        end
        if (pend_minus_r && slot_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = CHAR_MINUS;
          out_last_nxt   = 1'b0;
          pend_minus_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (pend_minus_r) begin
            out_valid_nxt  = 1'b1;
            out_char_nxt   = CHAR_MINUS;
            out_last_nxt   = 1'b0;
            pend_minus_nxt = 1'b0;
          end else begin
            // leading zeros are dropped, the units digit always goes out
            if (seen_r || (top_dig != 4'd0) || (dig_cnt_r == DIG_CNT_W'(1))) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = CHAR_ZERO + CHAR_W'(top_dig);
              out_last_nxt  = (dig_cnt_r == DIG_CNT_W'(1));
              seen_nxt      = 1'b1;
            end
            bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
            dig_cnt_nxt = dig_cnt_r - 1'b1;
            if (dig_cnt_r == DIG_CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_minus_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_minus_r <= pend_minus_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    seen_r     <= seen_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // A pending minus never outlives its number
  a_minus_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_minus_r)
    else $error("minus sign still pending in idle");

  // Converted digits are valid BCD while shifting out
  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (top_dig <= 4'd9))
    else $error("BCD digit out of range");

  // Only '-' or a decimal digit is ever presented
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS ||
                     (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_NINE)))
    else $error("output character is not a digit or minus");

  // An accepted integer starts conversion from bit zero
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CONV) && (bit_cnt_r == '0))
    else $error("conversion did not start after accept");

  // A minus is never flagged as the last character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked last");

endmodule
